// ===== src/bounded_topk_heap_top_defines.svh =====
// Assertion macros shared by the bounded top-K heap RTL.
`ifndef BOUNDED_TOPK_HEAP_TOP_DEFINES_SVH
`define BOUNDED_TOPK_HEAP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BTKH_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define BTKH_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define BTKH_ASSERT_IMPL(label, clk, rst, a, b)
`define BTKH_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== src/btkh_pkg.sv =====
// Package with types, codes and helpers of the bounded top-K heap.
`default_nettype none
package btkh_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam logic [6:0] CAP_RESET = 7'd8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ROOT_RD,
    S_ROOT_CHK,
    S_POP,
    S_POP_LD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CHK,
    S_APPEND,
    S_UP_RD,
    S_UP_CHK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [31:0]        key;
    logic [15:0]        handle;
  } entry_t;

  // Strictly lower score; ties compare false.
  function automatic logic lower(input logic signed [31:0] a, input logic signed [31:0] b);
    lower = (a < b);
  endfunction

endpackage
`default_nettype wire

// ===== src/bounded_topk_heap_top.sv =====
// Top level of the bounded top-K heap: sequencer, entry memory and result register.
//
// Channel   Direction  Handshake            Payload
// cfg       in         APB psel/penable     capacity at byte address 0
// request   in         in_valid/in_stall    req_type, score, selector_key, item_handle
// result    out        out_valid/out_stall  accepted, evicted_*, removed_*, occupancy
//
// An item holds the block for its whole run; in_stall is high until it is done.
// An insert scans the held items, one memory read per cycle, then may pop the root
// and walk the last item down, and may append the item and walk it up.
// A remove pops the root of a non-empty heap and walks the last item down; clear empties it.
// The entry memory has one read port and one write port, one address each a cycle.
// Reset (rst, synchronous) empties the heap and sets capacity to 8; no clearing pass.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none
`include "bounded_topk_heap_top_defines.svh"
module bounded_topk_heap_top #(
  parameter int MAX_ENTRIES = btkh_pkg::DEF_MAX_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] score,
  input  logic [31:0]        selector_key,
  input  logic [15:0]        item_handle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic               evicted_valid,
  output logic [15:0]        evicted_handle,
  output logic               removed_valid,
  output logic [15:0]        removed_handle,
  output logic signed [31:0] removed_score,
  output logic [6:0]         occupancy
);
  import btkh_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > 7) ? CW : 7;
  localparam int PW = AW + 1;

  // Configuration register.
  logic [6:0] capacity;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      capacity <= pwdata[6:0];
    end
  end
  assign prdata = paddr[2] ? 32'd0 : {25'd0, capacity};

  // Entry memory: one write and one registered read per cycle.
  entry_t          mem [MAX_ENTRIES];
  entry_t          rdata;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Sequencer registers.
  state_t          state, state_next;
  req_t            req, req_next;
  entry_t          item, item_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic [CW-1:0]   idx, idx_next;
  logic            pend, pend_next;
  logic            dup, dup_next;
  logic [AW-1:0]   pos, pos_next;
  entry_t          cur, cur_next;
  entry_t          lch, lch_next;
  logic            hasr, hasr_next;
  logic            r_acc, r_acc_next;
  logic            r_ev, r_ev_next;
  logic [15:0]     r_evh, r_evh_next;
  logic            r_rv, r_rv_next;
  logic [15:0]     r_rh, r_rh_next;
  logic [31:0]     r_rs, r_rs_next;
  logic            ov, ov_next;

  logic            take;
  logic [EW-1:0]   cnt_e, cap_e, eff_cap;
  logic [PW-1:0]   lidx, ridx, cnt_p;
  logic [AW-1:0]   parent;
  logic            pick_r;
  entry_t          child;
  logic [AW-1:0]   child_idx;

  assign take    = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cnt_e   = EW'(cnt);
  assign cap_e   = EW'(capacity);
  assign eff_cap = (capacity == 7'd0) ? EW'(1) :
                   ((cap_e > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : cap_e);
  assign cnt_p   = PW'(cnt);
  assign lidx    = {pos, 1'b1};
  assign ridx    = lidx + PW'(1);
  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign pick_r  = hasr && lower(rdata.score, lch.score);
  assign child   = pick_r ? rdata : lch;
  assign child_idx = pick_r ? ridx[AW-1:0] : lidx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    req   <= req_next;
    item  <= item_next;
    idx   <= idx_next;
    pend  <= pend_next;
    dup   <= dup_next;
    pos   <= pos_next;
    cur   <= cur_next;
    lch   <= lch_next;
    hasr  <= hasr_next;
    r_acc <= r_acc_next;
    r_ev  <= r_ev_next;
    r_evh <= r_evh_next;
    r_rv  <= r_rv_next;
    r_rh  <= r_rh_next;
    r_rs  <= r_rs_next;
  end

  always_comb begin
    state_next = state;
    req_next   = req;
    item_next  = item;
    cnt_next   = cnt;
    idx_next   = idx;
    pend_next  = pend;
    dup_next   = dup;
    pos_next   = pos;
    cur_next   = cur;
    lch_next   = lch;
    hasr_next  = hasr;
    r_acc_next = r_acc;
    r_ev_next  = r_ev;
    r_evh_next = r_evh;
    r_rv_next  = r_rv;
    r_rh_next  = r_rh;
    r_rs_next  = r_rs;
    ov_next    = ov && out_stall;
    raddr      = '0;
    we         = 1'b0;
    waddr      = pos;
    wdata      = cur;

    case (state)
      S_IDLE: begin
        if (take) begin
          req_next   = req_t'(req_type);
          item_next  = '{score: score, key: selector_key, handle: item_handle};
          idx_next   = '0;
          pend_next  = 1'b0;
          dup_next   = 1'b0;
          r_acc_next = 1'b0;
          r_ev_next  = 1'b0;
          r_evh_next = '0;
          r_rv_next  = 1'b0;
          r_rh_next  = '0;
          r_rs_next  = '0;
          case (req_t'(req_type))
            REQ_INSERT: state_next = S_SCAN;
            REQ_REMOVE: state_next = (cnt != '0) ? S_ROOT_RD : S_FIN;
            REQ_CLEAR: begin
              cnt_next   = '0;
              state_next = S_FIN;
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        // Reads run one ahead of the compares.
        raddr     = idx[AW-1:0];
        pend_next = (idx < cnt);
        if (idx < cnt) begin
          idx_next = idx + CW'(1);
        end
        if (pend && rdata.score == item.score && rdata.key == item.key) begin
          dup_next = 1'b1;
        end
        if (!(idx < cnt) && !pend) begin
          if (dup) begin
            state_next = S_FIN;
          end else if (cnt_e >= eff_cap) begin
            state_next = S_ROOT_RD;
          end else begin
            state_next = S_APPEND;
          end
        end
      end
      S_ROOT_RD: begin
        raddr      = '0;
        state_next = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        if (req == REQ_INSERT) begin
          if (lower(rdata.score, item.score)) begin
            r_ev_next  = 1'b1;
            r_evh_next = rdata.handle;
            state_next = S_POP;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          r_rv_next  = 1'b1;
          r_rh_next  = rdata.handle;
          r_rs_next  = rdata.score;
          state_next = S_POP;
        end
      end
      S_POP: begin
        raddr    = AW'(cnt - CW'(1));
        cnt_next = cnt - CW'(1);
        if (cnt == CW'(1)) begin
          state_next = (req == REQ_INSERT) ? S_APPEND : S_FIN;
        end else begin
          state_next = S_POP_LD;
        end
      end
      S_POP_LD: begin
        cur_next   = rdata;
        pos_next   = '0;
        state_next = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (lidx >= cnt_p) begin
          we         = 1'b1;
          state_next = (req == REQ_INSERT) ? S_APPEND : S_FIN;
        end else begin
          raddr      = lidx[AW-1:0];
          state_next = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lch_next  = rdata;
        hasr_next = (ridx < cnt_p);
        raddr     = ridx[AW-1:0];
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (lower(child.score, cur.score)) begin
          we         = 1'b1;
          wdata      = child;
          pos_next   = child_idx;
          state_next = S_DN_RDL;
        end else begin
          we         = 1'b1;
          state_next = (req == REQ_INSERT) ? S_APPEND : S_FIN;
        end
      end
      S_APPEND: begin
        if (cnt < CW'(MAX_ENTRIES)) begin
          cur_next   = item;
          pos_next   = AW'(cnt);
          cnt_next   = cnt + CW'(1);
          r_acc_next = 1'b1;
          state_next = S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_FIN;
        end else begin
          raddr      = parent;
          state_next = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        we = 1'b1;
        if (lower(cur.score, rdata.score)) begin
          wdata      = rdata;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov || !out_stall) begin
          ov_next    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result register, loaded when the sequencer finishes an item.
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!ov || !out_stall)) begin
      accepted       <= r_acc;
      evicted_valid  <= r_ev;
      evicted_handle <= r_evh;
      removed_valid  <= r_rv;
      removed_handle <= r_rh;
      removed_score  <= r_rs;
      occupancy      <= 7'(cnt);
    end
  end
  assign out_valid = ov;

  `BTKH_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(MAX_ENTRIES))
  `BTKH_ASSERT_NEXT(a_busy_after_take, clk, rst, take, state != S_IDLE)
  `BTKH_ASSERT_NEXT(a_fin_holds, clk, rst, state == S_FIN && ov && out_stall, state == S_FIN)
  `BTKH_ASSERT_IMPL(a_evict_stores, clk, rst, state == S_FIN, !r_ev || r_acc)

endmodule
`default_nettype wire

// ===== tb/bounded_topk_heap_top_test.sv =====
// Self-checking testbench for the bounded top-K heap top level.
`timescale 1ns / 1ps
module bounded_topk_heap_top_test;
  import btkh_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int RANDOM_ITEMS = 2000;

  // One result of the heap, as the block reports it.
  typedef struct {
    logic        accepted;
    logic        evicted_valid;
    logic [15:0] evicted_handle;
    logic        removed_valid;
    logic [15:0] removed_handle;
    logic [31:0] removed_score;
    logic [6:0]  occupancy;
  } heap_result_t;

  // One row of the directed table; has_fixed marks rows whose result is typed in.
  typedef struct {
    req_t         req;
    logic [31:0]  score;
    logic [31:0]  key;
    logic [15:0]  handle;
    bit           has_fixed;
    heap_result_t fixed;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = REQ_NONE;
  logic signed [31:0] score = '0;
  logic [31:0] selector_key = '0;
  logic [15:0] item_handle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic accepted, evicted_valid, removed_valid;
  logic [15:0] evicted_handle, removed_handle;
  logic signed [31:0] removed_score;
  logic [6:0] occupancy;

  bounded_topk_heap_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .score(score), .selector_key(selector_key),
    .item_handle(item_handle),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .evicted_valid(evicted_valid),
    .evicted_handle(evicted_handle), .removed_valid(removed_valid),
    .removed_handle(removed_handle), .removed_score(removed_score),
    .occupancy(occupancy)
  );

  always #6 clk = ~clk;

  // Shadow copy of the heap, kept in step with every accepted item.
  logic [31:0] shadow_scores [NUM_SLOTS];
  logic [31:0] shadow_keys [NUM_SLOTS];
  logic [15:0] shadow_handles [NUM_SLOTS];
  int unsigned shadow_count;
  logic [6:0] shadow_capacity;

  heap_result_t pending_results [$];
  int mismatch_count = 0;
  bit stall_enable = 1'b1;

  // Scores are signed, so a plain signed compare gives the heap order.
  function automatic bit score_below(int unsigned a, int unsigned b);
    return $signed(shadow_scores[a]) < $signed(shadow_scores[b]);
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [31:0] s, k;
    logic [15:0] h;
    s = shadow_scores[a]; shadow_scores[a] = shadow_scores[b]; shadow_scores[b] = s;
    k = shadow_keys[a]; shadow_keys[a] = shadow_keys[b]; shadow_keys[b] = k;
    h = shadow_handles[a]; shadow_handles[a] = shadow_handles[b]; shadow_handles[b] = h;
  endfunction

  // Take the root out: move the last item up and walk it down. Ties never move.
  function automatic void pop_worst();
    int unsigned pos, child;
    if (shadow_count == 0) return;
    shadow_count--;
    shadow_scores[0] = shadow_scores[shadow_count];
    shadow_keys[0] = shadow_keys[shadow_count];
    shadow_handles[0] = shadow_handles[shadow_count];
    pos = 0;
    forever begin
      child = 2 * pos + 1;
      if (child >= shadow_count) break;
      if (child + 1 < shadow_count && score_below(child + 1, child)) child++;
      if (!score_below(child, pos)) break;
      swap_slots(child, pos);
      pos = child;
    end
  endfunction

  function automatic heap_result_t predict_heap_step(req_t req, logic [31:0] s,
                                                     logic [31:0] k, logic [15:0] h);
    heap_result_t r;
    bit dup, ok;
    int unsigned limit, pos, parent;
    r = '{default: '0};
    case (req)
      REQ_INSERT: begin
        dup = 1'b0;
        ok = 1'b1;
        limit = (shadow_capacity == 0) ? 1 :
                (shadow_capacity > NUM_SLOTS) ? NUM_SLOTS : shadow_capacity;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_scores[i] == s && shadow_keys[i] == k) dup = 1'b1;
        if (dup) begin
          ok = 1'b0;
        end else if (shadow_count >= limit) begin
          if ($signed(s) > $signed(shadow_scores[0])) begin
            r.evicted_valid = 1'b1;
            r.evicted_handle = shadow_handles[0];
            pop_worst();
          end else begin
            ok = 1'b0;
          end
        end
        if (ok && shadow_count < NUM_SLOTS) begin
          shadow_scores[shadow_count] = s;
          shadow_keys[shadow_count] = k;
          shadow_handles[shadow_count] = h;
          pos = shadow_count;
          shadow_count++;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!score_below(pos, parent)) break;
            swap_slots(pos, parent);
            pos = parent;
          end
          r.accepted = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (shadow_count > 0) begin
          r.removed_valid = 1'b1;
          r.removed_handle = shadow_handles[0];
          r.removed_score = shadow_scores[0];
          pop_worst();
        end
      end
      REQ_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.occupancy = shadow_count[6:0];
    return r;
  endfunction

  // Wait out a random idle burst now and then, or none at all.
  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Hand one item to the block; the prediction is made when it is accepted.
  // Valid stays high after the accepting edge so that the next item can follow.
  task automatic send_item(req_t req, logic [31:0] s, logic [31:0] k, logic [15:0] h,
                           bit has_fixed, heap_result_t fixed, bit may_idle);
    heap_result_t r;
    maybe_idle(may_idle);
    in_valid <= 1'b1;
    req_type <= req;
    score <= s;
    selector_key <= k;
    item_handle <= h;
    do @(posedge clk); while (in_stall);
    r = predict_heap_step(req, s, k, h);
    if (has_fixed && r != fixed)
      $display("Directed row disagrees with prediction: req %0d", req);
    pending_results.push_back(has_fixed ? fixed : r);
  endtask

  // Register writes happen only when nothing is outstanding and the block is idle.
  task automatic write_capacity(logic [6:0] value);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0;
    pwdata <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shadow_capacity = value;
  endtask

  // Result side: random stall bursts, compare each item with the oldest expectation.
  always @(posedge clk) begin
    heap_result_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{accepted, evicted_valid, evicted_handle, removed_valid,
                removed_handle, removed_score, occupancy};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Result item with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected acc %b ev %b/%h rm %b/%h/%h occ %0d, ",
                       want.accepted, want.evicted_valid, want.evicted_handle,
                       want.removed_valid, want.removed_handle, want.removed_score,
                       want.occupancy,
                       "got acc %b ev %b/%h rm %b/%h/%h occ %0d",
                       got.accepted, got.evicted_valid, got.evicted_handle,
                       got.removed_valid, got.removed_handle, got.removed_score,
                       got.occupancy);
          end
        end
      end
    end
  end

  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (stall_enable && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Random request, mostly inserts but also removes, clears and no-ops, with scores drawn
  // from a narrow band, so that ties and duplicates are common, or from the full range.
  task automatic random_item(bit may_idle);
    int pick;
    logic [31:0] s, k;
    req_t req;
    pick = $urandom_range(0, 99);
    req = (pick < 62) ? REQ_INSERT : (pick < 92) ? REQ_REMOVE :
          (pick < 96) ? REQ_CLEAR : REQ_NONE;
    s = ($urandom_range(0, 1)) ? $urandom : 32'($signed($urandom_range(0, 15)) - 8);
    k = ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 3));
    send_item(req, s, k, 16'($urandom), 1'b0, '{default: '0}, may_idle);
  endtask

  initial begin
    directed_row_t rows [$];
    heap_result_t none;
    logic [6:0] capacities [6];
    none = '{default: '0};
    capacities = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd8};
    shadow_count = 0;
    shadow_capacity = CAP_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: empty remove, extremes, duplicate, full-heap replace, clear.
    rows.push_back('{REQ_REMOVE, 32'h0, 32'h0, 16'h0, 1'b1, none});
    rows.push_back('{REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, none});
    rows.push_back('{REQ_INSERT, 32'h8000_0000, 32'h0, 16'hFFFF, 1'b1,
                     '{1'b1, 1'b0, 16'h0, 1'b0, 16'h0, 32'h0, 7'd1}});
    rows.push_back('{REQ_INSERT, 32'h8000_0000, 32'h0, 16'h1234, 1'b1,
                     '{1'b0, 1'b0, 16'h0, 1'b0, 16'h0, 32'h0, 7'd1}});
    rows.push_back('{REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0, 1'b0, none});
    rows.push_back('{REQ_INSERT, 32'h0001_0000, 32'h5, 16'h0002, 1'b0, none});
    rows.push_back('{REQ_INSERT, 32'h0001_0000, 32'h6, 16'h0003, 1'b0, none});
    rows.push_back('{REQ_INSERT, 32'hFFFF_0000, 32'h5, 16'h0004, 1'b0, none});
    for (int i = 0; i < 6; i++)
      rows.push_back('{REQ_INSERT, 32'(i * 3 - 5), 32'(i), 16'(16'h100 + i), 1'b0, none});
    rows.push_back('{REQ_INSERT, 32'h8000_0000, 32'h9, 16'h0005, 1'b0, none});
    rows.push_back('{REQ_INSERT, 32'h7FFF_FFFF, 32'h9, 16'h0006, 1'b0, none});
    rows.push_back('{REQ_REMOVE, 32'h0, 32'h0, 16'h0, 1'b0, none});
    rows.push_back('{REQ_REMOVE, 32'h0, 32'h0, 16'h0, 1'b0, none});
    rows.push_back('{REQ_NONE, 32'h0, 32'h0, 16'h0, 1'b0, none});
    rows.push_back('{REQ_CLEAR, 32'h0, 32'h0, 16'h0, 1'b1, none});
    rows.push_back('{REQ_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0, 1'b1, none});
    foreach (rows[i])
      send_item(rows[i].req, rows[i].score, rows[i].key, rows[i].handle,
                rows[i].has_fixed, rows[i].fixed, 1'b1);

    // Random part over several capacities; the heap is kept loaded when it shrinks,
    // so the case of a count above the capacity is exercised too.
    foreach (capacities[c]) begin
      write_capacity(capacities[c]);
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        if (c == 5 && n > RANDOM_ITEMS / 6 - 60) stall_enable = 1'b0;
        random_item(!(c == 5 && n > RANDOM_ITEMS / 6 - 60));
      end
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
